// File: src/sv39m_pkg.sv
// ----------------------------------------------------------------------------
// sv39m_pkg
// Shared types and constants of the Sv39 page table mapper: payload
// structs, status codes and the controller to datapath signal groups.
// ----------------------------------------------------------------------------
package sv39m_pkg;

    localparam int ENTRIES_PER_LEVEL = 512;
    localparam int IDX_W             = 9;
    localparam int PPN_W             = 44;
    localparam int VA_W              = 39;
    localparam int PA_W              = 56;
    localparam int PTE_W             = 54;
    localparam int FLAGS_W           = 8;
    localparam int OFFSET_W          = 12;

    typedef enum logic [1:0] {
        ST_MAPPED    = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_OUTSIDE   = 2'd2
    } t_status;

    typedef struct packed {
        logic [VA_W-1:0]    virtual_address;
        logic [PA_W-1:0]    physical_address;
        logic [1:0]         leaf_level;
        logic [FLAGS_W-1:0] leaf_flags;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [PA_W-1:0]  leaf_entry_address;
        logic [PTE_W-1:0] leaf_entry_value;
        logic [1:0]       tables_allocated;
    } t_rsp;

    typedef logic [PPN_W-1:0] t_cfg;

    // commands from the controller
    typedef struct packed {
        logic clear;
        logic load;
        logic rd;
        logic eval;
        logic leaf;
        logic out_load;
    } t_cmd;

    // status back to the controller
    typedef struct packed {
        logic clear_last;
        logic req_walk;
        logic eval_fail;
        logic eval_more;
        logic out_free;
    } t_sts;

endpackage

// File: src/sv39m_chan_if.sv
// ----------------------------------------------------------------------------
// sv39m_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface sv39m_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/sv39_page_table_mapper.sv
// ----------------------------------------------------------------------------
// sv39_page_table_mapper
// Builds Sv39 mappings in an on-block pool of 512-entry page tables.
// ----------------------------------------------------------------------------
// Usage
//   i_req carries one map transaction: virtual address, physical address,
//   leaf level and flags. o_rsp returns one result transaction per request
//   with the status, the leaf entry address and value, and the number of
//   tables taken. i_cfg writes the page number of pool table zero and is
//   always ready; write it only while no request is in flight.
//   A request walks 2 - leaf level table levels after acceptance (level
//   three counts as two, a failed walk ends early): each walk level is a
//   table memory read state and then an evaluation state, since the next
//   index depends on the entry just read; the leaf write state and the
//   result hand-over state follow. The next request is accepted in the
//   cycle after the result moves to the output register.
//   After reset the table memory is cleared one entry a cycle, through
//   all POOL_TABLES * 512 entries, and i_req is not ready during that sweep.
//   The root table is preallocated; the allocator starts at table one.
//   When o_rsp stalls, the result waits in the output register and one
//   further request may complete its walk before the block holds.
// ----------------------------------------------------------------------------
module sv39_page_table_mapper #(
    parameter int POOL_TABLES = 64
) (
    input logic          i_clk,
    input logic          i_rst_n,
    sv39m_chan_if.sink   i_req,
    sv39m_chan_if.source o_rsp,
    sv39m_chan_if.sink   i_cfg
);

    sv39m_pkg::t_cmd cmd;
    sv39m_pkg::t_sts sts;
    logic            req_ready;

    sv39m_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sv39m_dpath #(
        .POOL_TABLES (POOL_TABLES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req_data  (i_req.data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_out_data  (o_rsp.data)
    );

    assign i_req.ready = req_ready;
    assign i_cfg.ready = 1'b1;

endmodule

// File: src/sv39m_ctrl.sv
// ----------------------------------------------------------------------------
// sv39m_ctrl
// Controller of the mapper: clearing sweep, walk sequencing per level,
// leaf write and hand-over of the result to the output register.
// ----------------------------------------------------------------------------
module sv39m_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  sv39m_pkg::t_sts i_sts,
    output sv39m_pkg::t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_EVAL  = 6'b001000,
        S_LEAF  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.req_walk ? S_READ : S_LEAF;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.eval_fail) begin
                    n_state = S_DONE;
                end else if (i_sts.eval_more) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_LEAF;
                end
            end
            S_LEAF: begin
                o_cmd.leaf = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// File: src/sv39m_dpath.sv
// ----------------------------------------------------------------------------
// sv39m_dpath
// Datapath of the mapper: table pool memory, walk registers, bump
// allocator, entry formatting and the output register.
// ----------------------------------------------------------------------------
module sv39m_dpath #(
    parameter int POOL_TABLES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sv39m_pkg::t_cmd i_cmd,
    output sv39m_pkg::t_sts o_sts,
    input  sv39m_pkg::t_req i_req_data,
    input  logic            i_cfg_valid,
    input  sv39m_pkg::t_cfg i_cfg_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output sv39m_pkg::t_rsp o_out_data
);

    localparam int TW    = $clog2(POOL_TABLES);
    localparam int AW    = TW + sv39m_pkg::IDX_W;
    localparam int DEPTH = POOL_TABLES * sv39m_pkg::ENTRIES_PER_LEVEL;
    localparam int CW    = $clog2(POOL_TABLES + 1);

    localparam int PPN_W = sv39m_pkg::PPN_W;
    localparam int PTE_W = sv39m_pkg::PTE_W;

    logic [PTE_W-1:0] r_mem [DEPTH];
    logic [PTE_W-1:0] r_rd_data;

    logic [PPN_W-1:0]                r_base;
    logic [sv39m_pkg::VA_W-1:0]      r_va;
    logic [PPN_W-1:0]                r_pa_ppn;
    logic [sv39m_pkg::FLAGS_W-1:0]   r_flags;
    logic [1:0]                      r_leaf;
    logic [1:0]                      r_lvl;
    logic [TW-1:0]                   r_tbl;
    logic [CW-1:0]                   r_next_free;
    logic [1:0]                      r_taken;
    sv39m_pkg::t_status              r_status;
    logic [sv39m_pkg::PA_W-1:0]      r_ent_addr;
    logic [PTE_W-1:0]                r_ent_val;
    logic [AW-1:0]                   r_clr_addr;
    logic                            r_out_valid;
    sv39m_pkg::t_rsp                 r_out;

    logic [sv39m_pkg::IDX_W-1:0] vpn;
    logic [AW-1:0]               walk_addr;
    logic                        ent_invalid;
    logic                        exhausted;
    logic [PPN_W-1:0]            new_page;
    logic [PTE_W-1:0]            ptr_entry;
    logic [PPN_W-1:0]            rel;
    logic                        rel_ok;
    logic [TW-1:0]               tbl_next;
    logic [1:0]                  lvl_dec;
    logic                        alloc;
    logic [PPN_W-1:0]            leaf_page;
    logic [PTE_W-1:0]            leaf_entry;
    logic [sv39m_pkg::PA_W-1:0]  leaf_addr;
    logic                        mem_we;
    logic [AW-1:0]               mem_wa;
    logic [PTE_W-1:0]            mem_wd;

    always_comb begin
        case (r_lvl)
            2'd2:    vpn = r_va[38:30];
            2'd1:    vpn = r_va[29:21];
            default: vpn = r_va[20:12];
        endcase
    end

    assign walk_addr   = {r_tbl, vpn};
    assign ent_invalid = !r_rd_data[0];
    assign exhausted   = r_next_free >= CW'(POOL_TABLES);
    assign new_page    = r_base + PPN_W'(r_next_free);
    assign ptr_entry   = {new_page, 2'b00, 8'h01};
    assign rel         = r_rd_data[PTE_W-1:10] - r_base;
    assign rel_ok      = rel < PPN_W'(POOL_TABLES);
    // a fresh table sits at base plus its index, so its offset is the index itself
    assign tbl_next    = ent_invalid ? r_next_free[TW-1:0] : rel[TW-1:0];
    assign lvl_dec     = r_lvl - 2'd1;
    assign alloc       = i_cmd.eval && ent_invalid && !exhausted;

    assign leaf_page  = r_base + PPN_W'(r_tbl);
    assign leaf_entry = {r_pa_ppn, 2'b00, r_flags | 8'h01};
    assign leaf_addr  = {leaf_page, vpn, 3'b000};

    assign o_sts.clear_last = r_clr_addr == AW'(DEPTH - 1);
    assign o_sts.req_walk   = !i_req_data.leaf_level[1];
    assign o_sts.eval_fail  = ent_invalid ? exhausted : !rel_ok;
    assign o_sts.eval_more  = lvl_dec > r_leaf;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = walk_addr;
        mem_wd = leaf_entry;
        if (i_cmd.clear) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = '0;
        end else if (alloc) begin
            mem_we = 1'b1;
            mem_wd = ptr_entry;
        end else if (i_cmd.leaf) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[walk_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_next_free <= CW'(1);
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            if (alloc) begin
                r_next_free <= r_next_free + CW'(1);
            end
            if (i_cmd.clear && !o_sts.clear_last) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_va       <= i_req_data.virtual_address;
            r_pa_ppn   <= i_req_data.physical_address[sv39m_pkg::PA_W-1:sv39m_pkg::OFFSET_W];
            r_flags    <= i_req_data.leaf_flags;
            r_leaf     <= i_req_data.leaf_level[1] ? 2'd2 : i_req_data.leaf_level;
            r_lvl      <= 2'd2;
            r_tbl      <= '0;
            r_taken    <= '0;
            r_status   <= sv39m_pkg::ST_MAPPED;
            r_ent_addr <= '0;
            r_ent_val  <= '0;
        end
        if (i_cmd.eval) begin
            if (alloc) begin
                r_taken <= r_taken + 2'd1;
            end
            if (o_sts.eval_fail) begin
                r_status <= ent_invalid ? sv39m_pkg::ST_EXHAUSTED : sv39m_pkg::ST_OUTSIDE;
            end else begin
                r_tbl <= tbl_next;
                r_lvl <= lvl_dec;
            end
        end
        if (i_cmd.leaf) begin
            r_ent_addr <= leaf_addr;
            r_ent_val  <= leaf_entry;
        end
        if (i_cmd.out_load) begin
            r_out.status             <= r_status;
            r_out.leaf_entry_address <= r_ent_addr;
            r_out.leaf_entry_value   <= r_ent_val;
            r_out.tables_allocated   <= r_taken;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_free_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free >= CW'(1) && r_next_free <= CW'(POOL_TABLES))
        else $error("free table count out of range");

    a_alloc_bumps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc |=> r_next_free == $past(r_next_free) + CW'(1))
        else $error("allocation did not advance the free table count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_taken_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> r_taken <= 2'd2)
        else $error("more than two tables taken by one request");

    a_no_write_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.leaf |-> r_status == sv39m_pkg::ST_MAPPED)
        else $error("leaf written after a failed walk");

endmodule
